[design/size_class_free_list_allocator_assert.svh]
// Assertion macros for the size-class free-list allocator.
// Included by the top level; depends on nothing else.
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// A condition that must hold at every clock edge out of reset.
`define SCFL_ASSERT_ALWAYS(lbl, ck, rstn, cond, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (cond)) else $error(msg);
// A condition that must hold in the same cycle as its trigger.
`define SCFL_ASSERT_SAME(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// A condition that must hold in the cycle after its trigger.
`define SCFL_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SCFL_ASSERT_ALWAYS(lbl, ck, rstn, cond, msg)
`define SCFL_ASSERT_SAME(lbl, ck, rstn, ante, cons, msg)
`define SCFL_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg)
`endif
`endif

[design/scfl_pkg.sv]
// Shared types and constants of the size-class free-list allocator.
// Used by the top level; depends on nothing.
package scfl_pkg;
	localparam int ADDR_W      = 20;
	localparam int SIZE_W      = 21;
	localparam int LIM_W       = 21;
	localparam int CLS_W       = 5;
	localparam int REQ_W       = 2;
	localparam int ST_W        = 2;
	localparam int LEN_W       = 20;
	localparam int WIDE_W      = 34;
	localparam int S_TDATA_W   = 48;
	localparam int M_TDATA_W   = 64;
	localparam logic [LIM_W-1:0] POOL_RESET = LIM_W'(1) << ADDR_W;
	localparam int BUMP_RESET  = 8;

	localparam int MIN_CLASS_DEF    = 3;
	localparam int BLOCK_CLASS_DEF  = 13;
	localparam int MAX_CLASS_DEF    = 19;
	localparam int HEADER_BYTES_DEF = 16;

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_FREE    = 2'd1,
		REQ_REALLOC = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_ZERO      = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_NO_MEM    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLS_RD,
		S_CLS_CHK,
		S_GRANT,
		S_POP_WAIT,
		S_CARVE,
		S_PUSH_RD,
		S_PUSH_LAT,
		S_PUSH_WR,
		S_FIN
	} state_t;
endpackage

[design/scfl_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
module scfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/size_class_free_list_allocator.sv]
// Channel   Dir  Ports                          Contents
// s_axis    in   s_tvalid s_tready s_tuser s_tdata  one request word
// m_axis    out  m_tvalid m_tready m_tdata      one result word per request
// cfg       in   cfg_we cfg_wdata                pool_limit write
//
// A free steps through PUSH_RD, PUSH_LAT, PUSH_WR and FIN, a pop through GRANT,
// POP_WAIT and FIN. A refill of a small class writes one linked item per cycle
// into link and class memories, 2^(BLOCK_CLASS-class) items; a large refill one.
// Reset needs no clearing pass: the memories are read only where written.
// A request is taken only in the idle state; a waiting result holds the
// sequencer in its final state until the output register frees.
// Depends on scfl_pkg, scfl_ram and size_class_free_list_allocator_assert.svh.
`include "size_class_free_list_allocator_assert.svh"
module size_class_free_list_allocator #(
	parameter int MIN_CLASS    = scfl_pkg::MIN_CLASS_DEF,
	parameter int BLOCK_CLASS  = scfl_pkg::BLOCK_CLASS_DEF,
	parameter int MAX_CLASS    = scfl_pkg::MAX_CLASS_DEF,
	parameter int HEADER_BYTES = scfl_pkg::HEADER_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [scfl_pkg::LIM_W-1:0]       cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [scfl_pkg::REQ_W-1:0]       s_tuser,   // req_type
	input  logic [scfl_pkg::S_TDATA_W-1:0]   s_tdata,   // size[20:0], addr[40:21]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [scfl_pkg::M_TDATA_W-1:0]   m_tdata    // addr_out, status, copy_src, copy_len
);
	import scfl_pkg::*;

	localparam int SLOT_W     = ADDR_W - MIN_CLASS;
	localparam int SLOT_DEPTH = 1 << SLOT_W;
	localparam int NCLS       = MAX_CLASS + 1;
	localparam int HIDX_W     = $clog2(NCLS);
	localparam int CNT_W      = BLOCK_CLASS - MIN_CLASS + 1;
	localparam int BP_W       = ADDR_W + 1;
	localparam logic [WIDE_W-1:0] MAX_SIZE = WIDE_W'(1) << MAX_CLASS;
	localparam logic [WIDE_W-1:0] POOL_TOP = WIDE_W'(1) << ADDR_W;
	localparam logic [BP_W-1:0]   BUMP_TOP = BP_W'(1) << ADDR_W;
	localparam int M_PAD_W = M_TDATA_W - (LEN_W + ADDR_W + ST_W + ADDR_W);

	state_t state_q, state_d;

	// Request and working registers.
	logic [REQ_W-1:0]  req_q;
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CLS_W-1:0]  ocls_q;
	logic [CLS_W-1:0]  gcls_q;
	logic [ADDR_W-1:0] got_q;
	status_t           st_q;
	logic [ADDR_W-1:0] src_q;
	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] d_q;
	logic [ADDR_W-1:0] item_q;
	logic [CNT_W-1:0]  rem_q;
	logic [BP_W-1:0]   bump_q;
	logic [LIM_W-1:0]  limit_q;
	logic [ADDR_W-1:0] heads_q [NCLS];
	logic              m_valid_q;
	logic [M_TDATA_W-1:0] m_data_q;

	// Input word fields.
	logic [SIZE_W-1:0] in_size;
	logic [ADDR_W-1:0] in_addr;
	assign in_size = s_tdata[SIZE_W-1:0];
	assign in_addr = s_tdata[SIZE_W+ADDR_W-1:SIZE_W];

	// Memory ports.
	logic              cls_we, link_we;
	logic [SLOT_W-1:0] cls_waddr, cls_raddr, link_waddr, link_raddr;
	logic [CLS_W-1:0]  cls_wdata, cls_rd;
	logic [ADDR_W-1:0] link_wdata, link_rd;

	scfl_ram #(.WIDTH(CLS_W), .DEPTH(SLOT_DEPTH)) u_cls_ram (
		.clk(clk), .we(cls_we), .waddr(cls_waddr), .wdata(cls_wdata),
		.raddr(cls_raddr), .rdata(cls_rd)
	);

	scfl_ram #(.WIDTH(ADDR_W), .DEPTH(SLOT_DEPTH)) u_link_ram (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.raddr(link_raddr), .rdata(link_rd)
	);

	// Size class of the pending request: bit length of size minus one, at least MIN_CLASS.
	logic [SIZE_W-1:0] sm1;
	logic [CLS_W-1:0]  blen, gc;
	always_comb begin
		sm1  = size_q - SIZE_W'(1);
		blen = '0;
		for (int i = 0; i < SIZE_W; i++) begin
			if (sm1[i]) begin
				blen = CLS_W'(i + 1);
			end
		end
		gc = (blen < CLS_W'(MIN_CLASS)) ? CLS_W'(MIN_CLASS) : blen;
	end

	// Refill sizing and the pool check.
	logic              size_zero, too_large, no_mem, fits, realloc_move, ocls_ok;
	logic [WIDE_W-1:0] g_item, g_need, lim_eff;
	logic [CNT_W-1:0]  g_count;
	always_comb begin
		size_zero = (size_q == '0);
		too_large = (WIDE_W'(size_q) > MAX_SIZE);
		g_item    = WIDE_W'(HEADER_BYTES) + (WIDE_W'(1) << gc);
		if (gc < CLS_W'(BLOCK_CLASS)) begin
			g_need  = g_item << (CLS_W'(BLOCK_CLASS) - gc);
			g_count = CNT_W'(1) << (CLS_W'(BLOCK_CLASS) - gc);
		end else begin
			g_need  = g_item;
			g_count = CNT_W'(1);
		end
		lim_eff = (WIDE_W'(limit_q) > POOL_TOP) ? POOL_TOP : WIDE_W'(limit_q);
		no_mem  = (WIDE_W'(bump_q) + g_need) > lim_eff;
		fits    = (WIDE_W'(1) << cls_rd) >= WIDE_W'(size_q);
		realloc_move = (req_q == REQ_REALLOC) && (addr_q != '0);
		ocls_ok = (ocls_q <= CLS_W'(MAX_CLASS));
	end

	// Single read and write index into the list heads.
	logic [HIDX_W-1:0] h_idx;
	logic [ADDR_W-1:0] heads_rd, heads_wdata;
	logic              heads_we;
	always_comb begin
		case (state_q)
			S_PUSH_WR: h_idx = ocls_ok ? HIDX_W'(ocls_q) : '0;
			S_GRANT:   h_idx = (gc <= CLS_W'(MAX_CLASS)) ? HIDX_W'(gc) : '0;
			default:   h_idx = HIDX_W'(gcls_q);
		endcase
		heads_rd = heads_q[h_idx];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						REQ_ALLOC: state_d = S_GRANT;
						REQ_FREE:  state_d = (in_addr == '0) ? S_FIN : S_PUSH_RD;
						REQ_REALLOC: begin
							if (in_addr == '0) begin
								state_d = S_GRANT;
							end else if (in_size == '0) begin
								state_d = S_PUSH_RD;
							end else begin
								state_d = S_CLS_RD;
							end
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_CLS_RD:  state_d = S_CLS_CHK;
			S_CLS_CHK: state_d = fits ? S_FIN : S_GRANT;
			S_GRANT: begin
				if (size_zero || too_large) begin
					state_d = S_FIN;
				end else if (heads_rd != '0) begin
					state_d = S_POP_WAIT;
				end else if (no_mem) begin
					state_d = S_FIN;
				end else begin
					state_d = S_CARVE;
				end
			end
			S_POP_WAIT: state_d = realloc_move ? S_PUSH_WR : S_FIN;
			S_CARVE: begin
				if (rem_q == CNT_W'(1)) begin
					state_d = realloc_move ? S_PUSH_WR : S_FIN;
				end
			end
			S_PUSH_RD:  state_d = S_PUSH_LAT;
			S_PUSH_LAT: state_d = S_PUSH_WR;
			S_PUSH_WR:  state_d = S_FIN;
			S_FIN:      state_d = (!m_valid_q || m_tready) ? S_IDLE : S_FIN;
			default:    state_d = S_IDLE;
		endcase
	end

	// Memory and list-head controls.
	always_comb begin
		s_tready   = (state_q == S_IDLE);
		cls_raddr  = addr_q[ADDR_W-1:MIN_CLASS];
		link_raddr = heads_rd[ADDR_W-1:MIN_CLASS];
		cls_we     = (state_q == S_CARVE);
		cls_waddr  = d_q[ADDR_W-1:MIN_CLASS];
		cls_wdata  = gcls_q;
		link_we    = 1'b0;
		link_waddr = addr_q[ADDR_W-1:MIN_CLASS];
		link_wdata = heads_rd;
		heads_we   = 1'b0;
		heads_wdata = addr_q;
		case (state_q)
			S_CARVE: begin
				// The first item of a run is granted, so its link stays unwritten.
				link_we    = (d_q != got_q);
				link_waddr = d_q[ADDR_W-1:MIN_CLASS];
				link_wdata = (rem_q > CNT_W'(1)) ? d_q + item_q : '0;
				heads_we   = (rem_q == CNT_W'(1)) && (gcls_q < CLS_W'(BLOCK_CLASS));
				heads_wdata = got_q + item_q;
			end
			S_POP_WAIT: begin
				heads_we    = 1'b1;
				heads_wdata = link_rd;
			end
			S_PUSH_WR: begin
				link_we  = ocls_ok;
				heads_we = ocls_ok;
			end
			default: begin
				link_we = 1'b0;
			end
		endcase
	end

	// Control state: sequencer, bump pointer, list heads, limit, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bump_q    <= BP_W'(BUMP_RESET);
			limit_q   <= POOL_RESET;
			m_valid_q <= 1'b0;
			for (int i = 0; i < NCLS; i++) begin
				heads_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (heads_we) begin
				heads_q[h_idx] <= heads_wdata;
			end
			if (state_q == S_GRANT && !size_zero && !too_large && heads_rd == '0
				&& !no_mem) begin
				bump_q <= bump_q + BP_W'(g_need);
			end
			if (state_q == S_FIN && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					req_q  <= s_tuser;
					size_q <= in_size;
					addr_q <= in_addr;
					got_q  <= '0;
					src_q  <= '0;
					len_q  <= '0;
					st_q   <= (s_tuser == REQ_REALLOC && in_addr != '0 && in_size == '0)
						? ST_ZERO : ST_OK;
				end
			end
			S_CLS_CHK: begin
				ocls_q <= cls_rd;
				if (fits) begin
					got_q <= addr_q;
				end
			end
			S_GRANT: begin
				gcls_q <= gc;
				if (size_zero) begin
					st_q <= ST_ZERO;
				end else if (too_large) begin
					st_q <= ST_TOO_LARGE;
				end else if (heads_rd != '0) begin
					got_q <= heads_rd;
				end else if (no_mem) begin
					st_q <= ST_NO_MEM;
				end else begin
					got_q  <= bump_q[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
					d_q    <= bump_q[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
					item_q <= g_item[ADDR_W-1:0];
					rem_q  <= g_count;
				end
			end
			S_POP_WAIT: begin
				if (realloc_move) begin
					src_q <= addr_q;
					len_q <= LEN_W'(WIDE_W'(1) << ocls_q);
				end
			end
			S_CARVE: begin
				d_q   <= d_q + item_q;
				rem_q <= rem_q - CNT_W'(1);
				if (rem_q == CNT_W'(1) && realloc_move) begin
					src_q <= addr_q;
					len_q <= LEN_W'(WIDE_W'(1) << ocls_q);
				end
			end
			S_PUSH_LAT: begin
				ocls_q <= cls_rd;
			end
			S_FIN: begin
				if (!m_valid_q || m_tready) begin
					m_data_q <= {{M_PAD_W{1'b0}}, len_q, src_q, st_q, got_q};
				end
			end
			default: begin
				d_q <= d_q;
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// Checks on the sequencer and datapath.
	`SCFL_ASSERT_ALWAYS(a_bump_in_pool, clk, arst_n, bump_q <= BUMP_TOP, "bump pointer left the pool")
	`SCFL_ASSERT_SAME(a_carve_count, clk, arst_n, state_q == S_CARVE, rem_q != '0, "refill count ran out")
	`SCFL_ASSERT_SAME(a_fail_null, clk, arst_n, m_tvalid && m_tdata[21:20] != ST_OK, m_tdata[19:0] == '0, "failed request granted an address")
	`SCFL_ASSERT_NEXT(a_zero_status, clk, arst_n, state_q == S_GRANT && size_q == '0, st_q == ST_ZERO, "zero size not reported")
endmodule

[bench/size_class_free_list_allocator_test.sv]
// Self-checking testbench of the size-class free-list allocator: directed and random requests
// checked word by word against a behavioural allocator model kept in this file.
// Depends on scfl_pkg and size_class_free_list_allocator.
`timescale 1ns / 100ps

module size_class_free_list_allocator_test;
	import scfl_pkg::*;

	localparam int NUM_CLASSES = MAX_CLASS_DEF + 1;
	localparam int PAUSE_CYCLES = 2100;

	typedef struct packed {
		logic [REQ_W-1:0]  kind;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] addr;
	} request_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr_out;
		status_t           status;
		logic [ADDR_W-1:0] copy_src;
		logic [LEN_W-1:0]  copy_len;
	} grant_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [LIM_W-1:0]     cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [REQ_W-1:0]     s_tuser;    // req_type
	logic [S_TDATA_W-1:0] s_tdata;    // size[20:0], addr[40:21], zeros
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;    // addr_out, status, copy_src, copy_len, zeros

	// Allocator model state.
	logic [ADDR_W-1:0] heads [NUM_CLASSES];
	logic [ADDR_W-1:0] links [int];
	logic [CLS_W-1:0]  classes [int];
	longint            bump;
	logic [LIM_W-1:0]  limit_reg;

	request_t          pending [$];
	grant_t            expected_grants [$];
	logic [ADDR_W-1:0] live_blocks [$];
	logic [ADDR_W-1:0] freed_blocks [$];
	int                errors;
	int                cycle;
	bit                tx_quiet;
	bit                rx_hold;

	size_class_free_list_allocator i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("size_class_free_list_allocator_test: errors");
		$finish;
	end

	function automatic int slot_of(logic [ADDR_W-1:0] a);
		return int'(a >> MIN_CLASS_DEF);
	endfunction

	// Pushes a block onto the list of its recorded class.
	function automatic void push_block(logic [ADDR_W-1:0] a);
		int c;
		c = classes[slot_of(a)];
		if (c > MAX_CLASS_DEF)
			return;
		links[slot_of(a)] = heads[c];
		heads[c] = a;
	endfunction

	// Pops the class list, or carves a fresh run from the bump pointer.
	function automatic status_t grant_block(longint size, output logic [ADDR_W-1:0] got);
		int     c;
		longint item, count, need, lim, base, d;
		c = MIN_CLASS_DEF;
		got = '0;
		if (size == 0)
			return ST_ZERO;
		if (size > (longint'(1) << MAX_CLASS_DEF))
			return ST_TOO_LARGE;
		while ((longint'(1) << c) < size)
			c++;
		if (heads[c] != 0) begin
			got = heads[c];
			heads[c] = links[slot_of(got)];
			return ST_OK;
		end
		item = HEADER_BYTES_DEF + (longint'(1) << c);
		count = (c < BLOCK_CLASS_DEF) ? (longint'(1) << (BLOCK_CLASS_DEF - c)) : 1;
		need = item * count;
		lim = limit_reg;
		if (lim > (longint'(1) << ADDR_W))
			lim = longint'(1) << ADDR_W;
		if (bump + need > lim)
			return ST_NO_MEM;
		base = bump;
		bump += need;
		for (longint k = 0; k < count; k++) begin
			d = base + k * item + HEADER_BYTES_DEF;
			classes[slot_of(ADDR_W'(d))] = CLS_W'(c);
			if (k >= 1)
				links[slot_of(ADDR_W'(d))] = (k + 1 < count) ? ADDR_W'(d + item) : '0;
		end
		if (count > 1)
			heads[c] = ADDR_W'(base + item + HEADER_BYTES_DEF);
		got = ADDR_W'(base + HEADER_BYTES_DEF);
		return ST_OK;
	endfunction

	// Works out the result word of one request.
	function automatic grant_t predict_grant(request_t r);
		grant_t  g;
		longint  have;
		g = '0;
		g.status = ST_OK;
		case (r.kind)
			REQ_ALLOC: g.status = grant_block(r.size, g.addr_out);
			REQ_FREE: if (r.addr != 0) push_block(r.addr);
			REQ_REALLOC: begin
				if (r.addr == 0) begin
					g.status = grant_block(r.size, g.addr_out);
				end else if (r.size == 0) begin
					push_block(r.addr);
					g.status = ST_ZERO;
				end else begin
					have = longint'(1) << classes[slot_of(r.addr)];
					if (have >= r.size) begin
						g.addr_out = r.addr;
					end else begin
						g.status = grant_block(r.size, g.addr_out);
						if (g.status == ST_OK) begin
							g.copy_src = r.addr;
							g.copy_len = LEN_W'(have);
							push_block(r.addr);
						end
					end
				end
			end
			default: ;
		endcase
		return g;
	endfunction

	function automatic void drop_live(logic [ADDR_W-1:0] a);
		int idx [$];
		idx = live_blocks.find_first_index(x) with (x == a);
		if (idx.size() != 0)
			live_blocks.delete(idx[0]);
		freed_blocks.push_back(a);
	endfunction

	// Queues one request with its expected result and tracks the blocks held.
	task automatic issue(logic [REQ_W-1:0] kind, longint size, logic [ADDR_W-1:0] a);
		request_t r;
		grant_t   g;
		r.kind = kind;
		r.size = SIZE_W'(size);
		r.addr = a;
		g = predict_grant(r);
		if (g.status == ST_OK && g.addr_out != 0 && g.addr_out != a)
			live_blocks.push_back(g.addr_out);
		if (kind == REQ_FREE && a != 0)
			drop_live(a);
		if (kind == REQ_REALLOC && a != 0 &&
		    (g.status == ST_ZERO || (g.status == ST_OK && g.addr_out != a)))
			drop_live(a);
		expected_grants.push_back(g);
		pending.push_back(r);
	endtask

	function automatic logic [ADDR_W-1:0] any_live();
		if (live_blocks.size() == 0)
			return '0;
		return live_blocks[$urandom_range(live_blocks.size() - 1)];
	endfunction

	function automatic longint pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(64, 1);
		if (r < 94) return $urandom_range(8192, 65);
		if (r < 96) return $urandom_range(1 << 19, 8193);
		if (r < 98) return 0;
		return $urandom_range((1 << 21) - 1, (1 << 19) + 1);
	endfunction

	task automatic random_requests(int n);
		int r;
		repeat (n) begin
			r = $urandom_range(99);
			if (live_blocks.size() > 150 && r < 40)
				r = 50;
			if (r < 45 || live_blocks.size() == 0)
				issue(REQ_ALLOC, pick_size(), '0);
			else if (r < 75)
				issue(REQ_FREE, 0, any_live());
			else if (r < 90)
				issue(REQ_REALLOC, pick_size(), ($urandom_range(9) == 0) ? '0 : any_live());
			else if (r < 93)
				issue(REQ_NONE, $urandom, ADDR_W'($urandom));
			else if (r < 95 && freed_blocks.size() != 0)
				issue(REQ_FREE, 0, freed_blocks[$urandom_range(freed_blocks.size() - 1)]);
			else
				issue(REQ_FREE, 0, '0);
		end
	endtask

	task automatic drain();
		while (pending.size() != 0 || expected_grants.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_limit(logic [LIM_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_reg = v;
	endtask

	// Request driver: offers the next pending word unless idling.
	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (pending.size() != 0 && (tx_quiet || $urandom_range(99) >= 37)) begin
				s_tvalid <= 1'b1;
				s_tuser <= pending[0].kind;
				s_tdata <= S_TDATA_W'({pending[0].addr, pending[0].size});
				void'(pending.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result side: random back-pressure and the comparison of each word.
	always @(posedge clk) begin
		grant_t got, want;
		cycle <= cycle + 1;
		tx_quiet <= (cycle >= 3000 && cycle < 6000);
		if (arst_n)
			m_tready <= !rx_hold && (cycle >= 3000 && cycle < 6000 || $urandom_range(99) >= 37);
		if (arst_n && m_tvalid && m_tready) begin
			got.addr_out = m_tdata[19:0];
			got.status = status_t'(m_tdata[21:20]);
			got.copy_src = m_tdata[41:22];
			got.copy_len = m_tdata[61:42];
			if (expected_grants.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word %h", m_tdata);
			end else begin
				want = expected_grants.pop_front();
				if (got !== want || m_tdata[63:62] !== 2'b00) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected addr %h st %0d src %h len %h, got addr %h st %0d src %h len %h",
							want.addr_out, want.status, want.copy_src, want.copy_len,
							got.addr_out, got.status, got.copy_src, got.copy_len);
				end
			end
		end
	end

	// Long hold-off on the result side so the block fills and stalls its input.
	initial begin
		rx_hold = 1'b0;
		wait (cycle == 800);
		rx_hold = 1'b1;
		repeat (PAUSE_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	// Stimulus: directed cases, then random phases under several pool limits.
	initial begin
		logic [ADDR_W-1:0] a, b;
		errors = 0;
		cycle = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		m_tready = 1'b0;
		tx_quiet = 1'b0;
		for (int i = 0; i < NUM_CLASSES; i++)
			heads[i] = '0;
		bump = BUMP_RESET;
		limit_reg = POOL_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		issue(REQ_ALLOC, 0, '0);
		issue(REQ_ALLOC, 1, '0);
		issue(REQ_ALLOC, 8, '0);
		issue(REQ_ALLOC, 9, '0);
		issue(REQ_ALLOC, 8192, '0);
		issue(REQ_ALLOC, 8193, '0);
		issue(REQ_ALLOC, 1 << 19, '0);
		issue(REQ_ALLOC, (1 << 19) + 1, '0);
		issue(REQ_ALLOC, (1 << 21) - 1, '0);
		issue(REQ_FREE, 0, '0);
		a = live_blocks[1];
		issue(REQ_FREE, 0, a);
		issue(REQ_FREE, 0, a);              // double free
		issue(REQ_ALLOC, 5, '0);
		issue(REQ_REALLOC, 20, '0);         // reallocate of null
		b = live_blocks[0];
		issue(REQ_REALLOC, 8, b);           // fits
		issue(REQ_REALLOC, 100, b);         // moves with copy
		issue(REQ_REALLOC, 0, any_live());  // reallocate to zero size
		issue(REQ_NONE, (1 << 21) - 1, '1); // unknown request
		issue(REQ_NONE, 0, '0);
		random_requests(600);
		drain();

		write_limit('0);
		issue(REQ_ALLOC, 4096, '0);
		issue(REQ_REALLOC, 1 << 19, any_live());  // allocation fails, block kept
		random_requests(60);
		drain();

		write_limit('1);
		random_requests(450);
		drain();

		write_limit(LIM_W'($urandom_range(1 << 20, 300000)));
		random_requests(450);
		drain();

		write_limit(POOL_RESET);
		random_requests(150);
		drain();

		if (expected_grants.size() == 0 && errors == 0)
			$display("size_class_free_list_allocator_test: clean");
		else
			$display("size_class_free_list_allocator_test: errors");
		$finish;
	end
endmodule

[sim.f]
+incdir+design
design/scfl_pkg.sv
design/scfl_ram.sv
design/size_class_free_list_allocator.sv
bench/size_class_free_list_allocator_test.sv
